// File: design/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared types and constants of the range scan converter
// Holds the fixed datapath widths, register codes, arctangent table and
// the output rounding and saturation used by the scaling unit.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int XY_W      = 35;  // CORDIC x/y datapath, holds 1.65 * 2^32
  localparam int Z_W       = 32;  // signed angle residual
  localparam int ANGLE_W   = 32;
  localparam int RANGE_W   = 16;
  localparam int COORD_W   = 17;
  localparam int HEIGHT_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int TBL_IDX_W = 5;
  localparam int GAIN_W    = 17;
  localparam int PROD_W    = XY_W + GAIN_W;

  localparam logic signed [GAIN_W-1:0] CORDIC_GAIN = 17'sd39797;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sd65535;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -17'sd65535;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ANGLE_START   = 3'd0;
  localparam cfg_idx_t REG_ANGLE_STEP    = 3'd1;
  localparam cfg_idx_t REG_RANGE_MIN     = 3'd2;
  localparam cfg_idx_t REG_LAYER_STEP    = 3'd3;

  localparam logic [ANGLE_W-1:0]  ANGLE_START_RST = 32'd2684354560;
  localparam logic [ANGLE_W-1:0]  ANGLE_STEP_RST  = 32'd2982616;
  localparam logic [RANGE_W-1:0]  RANGE_MIN_RST   = 16'd20;
  localparam logic [HEIGHT_W-1:0] LAYER_STEP_RST  = 16'd100;

  // Arctangent of 2^-i in 2^32-per-turn units.
  function automatic logic [Z_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half up at bit 32, then clamp to the symmetric coordinate range.
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-33:0] q;
    logic signed [COORD_W-1:0] r;
    rnd = p + PROD_W'(64'sd2147483648);
    q   = rnd[PROD_W-1:32];
    if (q > (PROD_W-32)'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (q < (PROD_W-32)'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = q[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/rsc_in_if.sv
// ----------------------------------------------------------------------------
// rsc_in_if: range sample channel
// Valid/ready channel carrying one range sample and its end-of-scan flag.
// ----------------------------------------------------------------------------
interface rsc_in_if import rsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               scan_end;

  modport source (output valid, output range_mm, output scan_end, input ready);
  modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

// File: design/rsc_out_if.sv
// ----------------------------------------------------------------------------
// rsc_out_if: point channel
// Valid/ready channel carrying one Cartesian point per range sample.
// ----------------------------------------------------------------------------
interface rsc_out_if import rsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kept;
  logic signed [COORD_W-1:0]  x_mm;
  logic signed [COORD_W-1:0]  y_mm;
  logic [HEIGHT_W-1:0]        z_mm;
  logic                       last_of_scan;

  modport source (output valid, output kept, output x_mm, output y_mm,
                  output z_mm, output last_of_scan, input ready);
  modport sink   (input valid, input kept, input x_mm, input y_mm,
                  input z_mm, input last_of_scan, output ready);
endinterface

// File: design/rsc_cfg_if.sv
// ----------------------------------------------------------------------------
// rsc_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rsc_cfg_if import rsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/rsc_cordic.sv
// ----------------------------------------------------------------------------
// rsc_cordic: iterative rotation-mode CORDIC
// Quarter-turn pre-rotation, then one micro-rotation per cycle through a
// single shared add/subtract and barrel-shift stage.
// ----------------------------------------------------------------------------
module rsc_cordic import rsc_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [RANGE_W-1:0]       range_in,
  input  logic [ANGLE_W-1:0]       angle_in,
  output logic                     done,
  output logic signed [XY_W-1:0]   x_out,
  output logic signed [XY_W-1:0]   y_out
);

  localparam int CW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

  logic signed [XY_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [1:0]             quad;
  logic [ANGLE_W-1:0]     angle_bias;
  logic signed [XY_W-1:0] big;
  logic signed [XY_W-1:0] dx, dy;
  logic [Z_W-1:0]         atan_v;

  // Quadrant from the angle rounded to the nearest quarter turn.
  assign angle_bias = angle_in + 32'h20000000;
  assign quad       = angle_bias[ANGLE_W-1:ANGLE_W-2];
  assign big        = signed'({3'b000, range_in, 16'h0000});

  assign dx     = y_r >>> cnt_r;
  assign dy     = x_r >>> cnt_r;
  assign atan_v = atan_turn(TBL_IDX_W'(cnt_r));

  always_comb begin
    if (!z_r[Z_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - signed'(atan_v);
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + signed'(atan_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(ITERATIONS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z_r <= signed'(angle_in - {quad, 30'd0});
      case (quad)
        2'd0: begin
          x_r <= big;
          y_r <= '0;
        end
        2'd1: begin
          x_r <= '0;
          y_r <= big;
        end
        2'd2: begin
          x_r <= -big;
          y_r <= '0;
        end
        default: begin
          x_r <= '0;
          y_r <= -big;
        end
      endcase
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

// File: design/rsc_scale.sv
// ----------------------------------------------------------------------------
// rsc_scale: CORDIC gain correction
// One shared multiplier scales x, then y, by the inverse CORDIC gain and
// rounds and clamps each to a 17-bit coordinate.
// ----------------------------------------------------------------------------
module rsc_scale import rsc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [XY_W-1:0]    x_in,
  input  logic signed [XY_W-1:0]    y_in,
  output logic                      done,
  output logic signed [COORD_W-1:0] x_out,
  output logic signed [COORD_W-1:0] y_out
);

  logic                      run_r;
  logic                      second_r;
  logic                      done_r;
  logic signed [XY_W-1:0]    y_hold_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [XY_W-1:0]    mul_a;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [COORD_W-1:0] x_r, y_r;

  assign mul_a = start ? x_in : y_hold_r;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(CORDIC_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      second_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r    <= 1'b1;
        second_r <= 1'b0;
      end else if (run_r) begin
        if (second_r) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          second_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y_hold_r <= y_in;
      prod_r   <= mul_p;
    end else if (run_r) begin
      if (second_r) begin
        y_r <= round_sat(prod_r);
      end else begin
        x_r    <= round_sat(prod_r);
        prod_r <= mul_p;
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

// File: design/range_scan_to_cartesian_points_unit.sv
// ----------------------------------------------------------------------------
// range_scan_to_cartesian_points_unit: range samples to x/y/z points
// Converts each laser range sample at the running beam angle into a point
// with an iterative CORDIC and a gain-correcting multiplier.
// ----------------------------------------------------------------------------
// Path: a kept sample passes from the pending registers through the CORDIC
//   and the gain multiplier to the output register; a dropped sample skips both.
// Samples: a new sample is taken only in idle, after the previous point is
//   loaded into the output register; the single micro-rotation stage is reused.
// Reset: synchronous, active low; registers return to their documented
//   values, beam angle to the angle_start reset value, layer height to zero.
// ----------------------------------------------------------------------------
module range_scan_to_cartesian_points_unit import rsc_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int RANGE_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rsc_in_if.sink      in_chan,
  rsc_out_if.source   out_chan,
  rsc_cfg_if.sink     cfg_chan
);

  // Only the low RANGE_BITS bits of a sample carry range.
  localparam int RB_USE = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam logic [RANGE_W-1:0] RANGE_MASK = RANGE_W'((33'd1 << RB_USE) - 33'd1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROT   = 4'b0010,
    S_SCALE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [ANGLE_W-1:0]  angle_start_r;
  logic [ANGLE_W-1:0]  angle_step_r;
  logic [RANGE_W-1:0]  range_min_r;
  logic [HEIGHT_W-1:0] layer_step_r;

  // Scan state.
  logic [ANGLE_W-1:0]  beam_angle_r;
  logic [HEIGHT_W-1:0] layer_height_r;

  // Fields of the sample in flight.
  logic                pend_kept_r;
  logic [HEIGHT_W-1:0] pend_z_r;
  logic                pend_last_r;
  logic [RANGE_W-1:0]  pend_range_r;
  logic [ANGLE_W-1:0]  pend_angle_r;

  // Output register.
  logic                      out_valid_r;
  logic                      out_kept_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic [HEIGHT_W-1:0]       out_z_r;
  logic                      out_last_r;

  logic                in_xfer;
  logic                out_xfer;
  logic                out_load;
  logic [RANGE_W-1:0]  range_eff;
  logic                keep;
  logic [HEIGHT_W:0]   height_sum;

  logic                      rot_busy_seen_r;
  logic                      rot_start;
  logic                      rot_done;
  logic signed [XY_W-1:0]    rot_x, rot_y;
  logic                      scl_done;
  logic signed [COORD_W-1:0] scl_x, scl_y;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign out_xfer  = out_valid_r && out_chan.ready;
  assign range_eff = in_chan.range_mm & RANGE_MASK;
  assign keep      = (range_eff >= range_min_r);
  assign height_sum = {1'b0, layer_height_r} + {1'b0, layer_step_r};

  // Output register is free when empty or emptied by this cycle's transfer.
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  // Kick the CORDIC in the first S_ROT cycle, the cycle after a kept sample lands.
  assign rot_start = (state_r == S_ROT) && !rot_busy_seen_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = keep ? S_ROT : S_OUT;
        end
      end
      S_ROT: begin
        if (rot_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (scl_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      rot_busy_seen_r <= 1'b0;
      angle_start_r   <= ANGLE_START_RST;
      angle_step_r    <= ANGLE_STEP_RST;
      range_min_r     <= RANGE_MIN_RST;
      layer_step_r    <= LAYER_STEP_RST;
      beam_angle_r    <= ANGLE_START_RST;
      layer_height_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      rot_busy_seen_r <= (state_r == S_ROT);

      // Register writes; unknown indexes are dropped.
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_ANGLE_START: angle_start_r <= cfg_chan.data;
          REG_ANGLE_STEP:  angle_step_r  <= cfg_chan.data;
          REG_RANGE_MIN:   range_min_r   <= cfg_chan.data[RANGE_W-1:0];
          REG_LAYER_STEP:  layer_step_r  <= cfg_chan.data[HEIGHT_W-1:0];
          default: ;
        endcase
      end

      // Advance the beam angle on every sample; reload and raise the
      // layer, saturating, at the end of a scan.
      if (in_xfer) begin
        if (in_chan.scan_end) begin
          beam_angle_r   <= angle_start_r;
          layer_height_r <= height_sum[HEIGHT_W] ? {HEIGHT_W{1'b1}}
                                                 : height_sum[HEIGHT_W-1:0];
        end else begin
          beam_angle_r <= beam_angle_r + angle_step_r;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the sample's fields at its transfer; they hold until output.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_kept_r  <= keep;
      pend_z_r     <= layer_height_r;
      pend_last_r  <= in_chan.scan_end;
      pend_range_r <= range_eff;
      pend_angle_r <= beam_angle_r;
    end
    if (out_load) begin
      out_kept_r <= pend_kept_r;
      out_x_r    <= pend_kept_r ? scl_x : '0;
      out_y_r    <= pend_kept_r ? scl_y : '0;
      out_z_r    <= pend_z_r;
      out_last_r <= pend_last_r;
    end
  end

  rsc_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rot_start),
    .range_in (pend_range_r),
    .angle_in (pend_angle_r),
    .done     (rot_done),
    .x_out    (rot_x),
    .y_out    (rot_y)
  );

  rsc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rot_done),
    .x_in  (rot_x),
    .y_in  (rot_y),
    .done  (scl_done),
    .x_out (scl_x),
    .y_out (scl_y)
  );

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kept         = out_kept_r;
  assign out_chan.x_mm         = out_x_r;
  assign out_chan.y_mm         = out_y_r;
  assign out_chan.z_mm         = out_z_r;
  assign out_chan.last_of_scan = out_last_r;

endmodule

// File: design/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker: port-level checks of the range scan converter
// Watches the sample and point channels and flags behavior the block must
// never show; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module rsc_checker import rsc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_kept,
  input logic signed [COORD_W-1:0] out_x_mm,
  input logic signed [COORD_W-1:0] out_y_mm
);

  // A stalled point stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("point dropped while stalled");

  // A dropped sample reports the origin.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kept |-> (out_x_mm == '0) && (out_y_mm == '0))
    else $error("dropped sample with nonzero coordinates");

  // Coordinates stay inside the clamped range.
  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_mm != -17'sd65536) && (out_y_mm != -17'sd65536))
    else $error("coordinate outside clamp range");

  // One sample at a time: no new transfer right after one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while another is in flight");

endmodule

bind range_scan_to_cartesian_points_unit rsc_checker u_rsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kept  (out_chan.kept),
  .out_x_mm  (out_chan.x_mm),
  .out_y_mm  (out_chan.y_mm)
);
